FILE: src/s2dec_pkg.sv
package s2dec_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int MAX_VALUE_BITS = 64;
    // Headroom so that nine times the top power of ten cannot overflow.
    localparam int CALC_EXTRA = 4;
    localparam int POW_W = MAX_VALUE_BITS + CALC_EXTRA;
    localparam int RADIX = 10;
    localparam int MAX_POW = 20;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic load;        // capture sign and magnitude of a new value
        logic count;       // find the number of digits
        logic emit_sign;   // load '-' into the output register
        logic emit_digit;  // load the next digit, strip it from the magnitude
    } s2dec_cmd_t;

    typedef struct packed {
        logic neg;         // captured value was negative
        logic last_digit;  // next digit is the final one
        logic out_free;    // output register can take a character this cycle
    } s2dec_status_t;

    // Ten to the power k, for elaboration-time tables.
    function automatic logic [POW_W-1:0] pow10(input int k);
        logic [POW_W-1:0] p;
        p = POW_W'(1);
        for (int i = 0; i < MAX_POW; i++)
        begin
            if (i < k)
            begin
                p = p * POW_W'(RADIX);
            end
        end
        return p;
    endfunction

    // Decimal digits of the largest magnitude, two to the power bits-1.
    function automatic int num_digits(input int bits);
        logic [POW_W-1:0] lim;
        int n;
        lim = POW_W'(1) << (bits - 1);
        n = 1;
        for (int k = 1; k < MAX_POW; k++)
        begin
            if (pow10(k) <= lim)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

endpackage

FILE: src/s2dec_if.sv
interface s2dec_in_if
    import s2dec_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface s2dec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

FILE: src/s2dec_datapath.sv
module s2dec_datapath
    import s2dec_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [VALUE_BITS-1:0] value,
    input  s2dec_cmd_t                   cmd,
    output s2dec_status_t                status,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [7:0]                   out_char,
    output logic                         out_last
);

    localparam int DIGITS = num_digits(VALUE_BITS);
    localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CALC_W = VALUE_BITS + CALC_EXTRA;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [CALC_W-1:0] pow_tab  [DIGITS];
    logic [CALC_W-1:0] mult_tab [DIGITS][RADIX];

    logic [CALC_W-1:0] mag_ext;
    logic [IDX_W-1:0]  top_idx;
    logic [3:0]        digit;
    logic [CALC_W-1:0] sub_val;

    for (genvar k = 0; k < DIGITS; k++)
    begin : g_pow
        localparam logic [POW_W-1:0] P = pow10(k);
        assign pow_tab[k] = P[CALC_W-1:0];
        for (genvar d = 0; d < RADIX; d++)
        begin : g_mult
            localparam logic [POW_W-1:0] M = P * POW_W'(d);
            assign mult_tab[k][d] = M[CALC_W-1:0];
        end
    end

    assign mag_ext = {{CALC_EXTRA{1'b0}}, mag_reg};

    // Index of the leading digit: highest power of ten not above the magnitude.
    always_comb
    begin
        top_idx = '0;
        for (int k = 1; k < DIGITS; k++)
        begin
            if (mag_ext >= pow_tab[k])
            begin
                top_idx = IDX_W'(k);
            end
        end
    end

    // Current digit: largest multiple of the current power that still fits.
    always_comb
    begin
        digit = '0;
        for (int d = 1; d < RADIX; d++)
        begin
            if (mag_ext >= mult_tab[idx_reg][d])
            begin
                digit = 4'(d);
            end
        end
        sub_val = mult_tab[idx_reg][digit];
    end

    always_comb
    begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            neg_next = value[VALUE_BITS-1];
            mag_next = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        end
        if (cmd.count)
        begin
            idx_next = top_idx;
        end
        if (cmd.emit_sign)
        begin
            char_next      = CHAR_MINUS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            char_next      = CHAR_ZERO + {4'b0, digit};
            last_next      = (idx_reg == '0);
            out_valid_next = 1'b1;
            mag_next       = mag_reg - sub_val[VALUE_BITS-1:0];
            idx_next       = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg        = neg_reg;
    assign status.last_digit = (idx_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

FILE: src/s2dec_ctrl.sv
module s2dec_ctrl
    import s2dec_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  s2dec_status_t status,
    output s2dec_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = status.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Sequence: the input transaction loads the value, the count state finds the number of digits,
// then the optional sign and the digits go through the output register. Once output runs, one
// character per cycle while the sink is ready, set by the digit-extraction step that strips
// one decimal digit per cycle.
// Reset: rst_n asynchronous, active low; clears the controller and the output valid.
module signed_int_to_decimal_ascii
    import s2dec_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    s2dec_in_if.sink     number,
    s2dec_out_if.source  text
);

    // Command and status between the sequencer and the datapath.
    s2dec_cmd_t    cmd;
    s2dec_status_t status;

    // Sequencer: idle -> count digits -> optional sign -> one digit per cycle while output is free.
    // It takes a new input transaction as soon as the last digit of the
    // previous number has moved into the output register.
    s2dec_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: holds the magnitude, finds the leading power of ten, then
    // peels off digits most significant first by comparing against the nine
    // multiples of the current power and subtracting the largest that fits.
    // The output register holds each character for the sink; conversion waits while it is not free.
    s2dec_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (number.value),
        .cmd       (cmd),
        .status    (status),
        .out_ready (text.ready),
        .out_valid (text.valid),
        .out_char  (text.text_char),
        .out_last  (text.last)
    );

endmodule
